### rtl/bps_pkg.sv
// Shared types, constants and helpers for the bilinear pixel sampler.
`default_nettype none

package bps_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W = 16;
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 9;
    // Wide enough for a coordinate's integer part plus one, and for any size register
    localparam int CMP_W   = COORD_W + 1;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    // Queue depths
    localparam int OP_QDEPTH = 4;
    localparam int OUT_DEPTH = 8;

    localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SAMPLE,
        OP_REJECT
    } op_kind_t;

    typedef struct packed {
        logic             oor;
        logic [PIX_W-1:0] pixel;
    } res_t;

    // Width of one decoded operation in the queue between front and back
    function automatic int op_width(input int addr_w, input int frac_w);
        return $bits(op_kind_t) + addr_w + 2 * frac_w + PIX_W;
    endfunction

endpackage

`default_nettype wire

### rtl/bps_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/bps_fifo.sv
// Small register FIFO with show-ahead head and fill count.
`default_nettype none

module bps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head,
    output logic                  empty,
    output logic                  full,
    output logic      [CNT_W-1:0] count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

### rtl/bps_front.sv
// Front end: splits coordinates, checks bounds and builds the queued operation.
`default_nettype none

module bps_front #(
    parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS,
    localparam int OP_W = bps_pkg::op_width($clog2(MAX_WIDTH * MAX_HEIGHT), FRAC_BITS)
) (
    input  wire logic                        cmd,
    input  wire logic [bps_pkg::COORD_W-1:0] coord_x,
    input  wire logic [bps_pkg::COORD_W-1:0] coord_y,
    input  wire logic [bps_pkg::PIX_W-1:0]   pixel_in,
    input  wire logic [bps_pkg::CFG_W-1:0]   image_width,
    input  wire logic [bps_pkg::CFG_W-1:0]   image_height,
    output logic      [OP_W-1:0]             op
);

    import bps_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int LIN_W  = CMP_W + $clog2(MAX_WIDTH) + 1;
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        op_kind_t              kind;
        logic [ADDR_W-1:0]     addr;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fy;
        logic [PIX_W-1:0]      pixel;
    } op_t;

    logic [CMP_W-1:0] col, row;
    logic [CMP_W-1:0] w_eff, h_eff;
    logic [LIN_W-1:0] lin;
    logic             write_ok, sample_ok;
    op_t              op_d;

    assign col = CMP_W'(coord_x >> FRAC_BITS);
    assign row = CMP_W'(coord_y >> FRAC_BITS);

    // Size registers above the store's extent act as the maximum
    assign w_eff = (CMP_W'(image_width) > CMP_W'(MAX_WIDTH))
                 ? CMP_W'(MAX_WIDTH) : CMP_W'(image_width);
    assign h_eff = (CMP_W'(image_height) > CMP_W'(MAX_HEIGHT))
                 ? CMP_W'(MAX_HEIGHT) : CMP_W'(image_height);

    assign write_ok  = (col < w_eff) && (row < h_eff);
    assign sample_ok = ((col + 1'b1) < w_eff) && ((row + 1'b1) < h_eff);

    assign lin = LIN_W'(row) * LIN_W'(MAX_WIDTH) + LIN_W'(col);

    always_comb
    begin
        op_d.addr  = lin[ADDR_W-1:0];
        op_d.fx    = coord_x[FRAC_BITS-1:0];
        op_d.fy    = coord_y[FRAC_BITS-1:0];
        op_d.pixel = pixel_in;
        unique case (cmd)
            CMD_WRITE:  op_d.kind = write_ok ? OP_WRITE : OP_REJECT;
            CMD_SAMPLE: op_d.kind = sample_ok ? OP_SAMPLE : OP_REJECT;
            default:    op_d.kind = OP_REJECT;
        endcase
    end

    assign op = op_d;

endmodule

`default_nettype wire

### rtl/bps_back.sv
// Back end: image RAM sequencer, neighbor capture and two-stage blend pipeline.
`default_nettype none

module bps_back #(
    parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS,
    localparam int OP_W   = bps_pkg::op_width($clog2(MAX_WIDTH * MAX_HEIGHT), FRAC_BITS),
    localparam int OCNT_W = $clog2(bps_pkg::OUT_DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire logic [OP_W-1:0]   q_head,
    output logic                   q_pop,
    input  wire logic [OCNT_W-1:0] out_count,
    output logic                   res_valid,
    output bps_pkg::res_t          res
);

    import bps_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WGT_W  = FRAC_BITS + 1;
    localparam int XP_W   = WGT_W + PIX_W;
    localparam int TOP_W  = PIX_W + FRAC_BITS;
    localparam int SUM_W  = PIX_W + 2 * FRAC_BITS;
    localparam int YP_W   = WGT_W + TOP_W;
    localparam int CRED_W = OCNT_W + 2;
    localparam logic [WGT_W-1:0] SCALE = WGT_W'(2 ** FRAC_BITS);

    // Neighbor read order
    localparam logic [1:0] RD_P00 = 2'd0;
    localparam logic [1:0] RD_P10 = 2'd1;
    localparam logic [1:0] RD_P01 = 2'd2;
    localparam logic [1:0] RD_P11 = 2'd3;

    typedef struct packed {
        op_kind_t              kind;
        logic [ADDR_W-1:0]     addr;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fy;
        logic [PIX_W-1:0]      pixel;
    } op_t;

    op_t               head;
    logic [1:0]        idx_reg, idx_next;
    logic [CRED_W-1:0] used;
    logic              issue;
    logic              is_sample;
    logic              last;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_rdata;

    // Read stage: one RAM access per cycle unless issue is held; read data returns in the next cycle
    logic                 s1_valid_reg, s1_tok_reg;
    logic [1:0]           s1_idx_reg;
    op_kind_t             s1_kind_reg;
    logic [FRAC_BITS-1:0] s1_fx_reg, s1_fy_reg;
    logic [PIX_W-1:0]     p00_reg, p10_reg, p01_reg;

    // Blend along x
    logic                 s2_valid_reg;
    op_kind_t             s2_kind_reg;
    logic [FRAC_BITS-1:0] s2_fx_reg, s2_fy_reg;
    logic [PIX_W-1:0]     s2_p00_reg, s2_p10_reg, s2_p01_reg, s2_p11_reg;
    logic [WGT_W-1:0]     wx_inv;
    logic [XP_W-1:0]      top_sum, bot_sum;

    // Blend along y
    logic                 s3_valid_reg;
    op_kind_t             s3_kind_reg;
    logic [FRAC_BITS-1:0] s3_fy_reg;
    logic [TOP_W-1:0]     s3_top_reg, s3_bot_reg;
    logic [WGT_W-1:0]     wy_inv;
    logic [YP_W-1:0]      y_sum;

    assign head      = op_t'(q_head);
    assign is_sample = (head.kind == OP_SAMPLE);
    assign last      = !is_sample || (idx_reg == RD_P11);

    // Hold issue while the output queue could not take every result in flight
    assign used  = CRED_W'(out_count) + CRED_W'(s1_tok_reg)
                 + CRED_W'(s2_valid_reg) + CRED_W'(s3_valid_reg);
    assign issue = !q_empty && (used < CRED_W'(OUT_DEPTH));
    assign q_pop = issue && last;
    assign ram_we = issue && (head.kind == OP_WRITE);

    always_comb
    begin
        unique case (idx_reg)
            RD_P00:  ram_addr = head.addr;
            RD_P10:  ram_addr = head.addr + ADDR_W'(1);
            RD_P01:  ram_addr = head.addr + ADDR_W'(MAX_WIDTH);
            RD_P11:  ram_addr = head.addr + ADDR_W'(MAX_WIDTH + 1);
            default: ram_addr = head.addr;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (issue && is_sample)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    bps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_image (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.pixel),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= RD_P00;
            s1_valid_reg <= 1'b0;
            s1_tok_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            s1_valid_reg <= issue;
            s1_tok_reg   <= issue && last;
            s2_valid_reg <= s1_tok_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= idx_reg;
        s1_kind_reg <= head.kind;
        s1_fx_reg   <= head.fx;
        s1_fy_reg   <= head.fy;

        if (s1_valid_reg && (s1_kind_reg == OP_SAMPLE))
        begin
            case (s1_idx_reg)
                RD_P00:  p00_reg <= ram_rdata;
                RD_P10:  p10_reg <= ram_rdata;
                RD_P01:  p01_reg <= ram_rdata;
                default: ;
            endcase
        end

        s2_kind_reg <= s1_kind_reg;
        s2_fx_reg   <= s1_fx_reg;
        s2_fy_reg   <= s1_fy_reg;
        s2_p00_reg  <= p00_reg;
        s2_p10_reg  <= p10_reg;
        s2_p01_reg  <= p01_reg;
        s2_p11_reg  <= ram_rdata;

        s3_kind_reg <= s2_kind_reg;
        s3_fy_reg   <= s2_fy_reg;
        s3_top_reg  <= top_sum[TOP_W-1:0];
        s3_bot_reg  <= bot_sum[TOP_W-1:0];
    end

    // Convex weights keep each row blend below 256 * SCALE
    assign wx_inv  = SCALE - WGT_W'(s2_fx_reg);
    assign top_sum = XP_W'(wx_inv) * XP_W'(s2_p00_reg) + XP_W'(s2_fx_reg) * XP_W'(s2_p10_reg);
    assign bot_sum = XP_W'(wx_inv) * XP_W'(s2_p01_reg) + XP_W'(s2_fx_reg) * XP_W'(s2_p11_reg);

    // Blend from the upper row toward the lower row, then truncate
    assign wy_inv = SCALE - WGT_W'(s3_fy_reg);
    assign y_sum  = YP_W'(wy_inv) * YP_W'(s3_top_reg) + YP_W'(s3_fy_reg) * YP_W'(s3_bot_reg);

    assign res_valid = s3_valid_reg;
    assign res.pixel = (s3_kind_reg == OP_SAMPLE) ? y_sum[SUM_W-1 -: PIX_W] : '0;
    assign res.oor   = (s3_kind_reg == OP_REJECT);

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used <= CRED_W'(OUT_DEPTH))
        else $error("results in flight exceed output queue room");

    a_read_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && is_sample && (idx_reg == RD_P11)) |=> (idx_reg == RD_P00))
        else $error("neighbor read index did not return to the first pixel");

    a_res_timing: assert property (@(posedge clk) disable iff (!rst_n)
        s1_tok_reg |-> ##2 res_valid)
        else $error("result did not leave the blend pipeline on time");

endmodule

`default_nettype wire

### rtl/bilinear_pixel_sampler.sv
// Bilinear pixel sampler top level: size registers, queues, front and back ends.
//
// Input stream (s_*): tuser carries cmd (0 write pixel, 1 sample). tdata carries
// coord_x [15:0], coord_y [31:16] and pixel_in [39:32]. Coordinates are 8.8
// fixed point by default. Every input beat yields exactly one output beat, in
// order: tdata [7:0] is pixel_out and tuser is out_of_range.
// APB port: image_width at 0x0, image_height at 0x4, 9 bits each, reset 256.
// Write them only while the block is idle.
// Issue: a write or an out-of-range item is issued once; an in-range sample is
// issued once per neighbor read, four in turn, on the single-port image RAM.
// The next item waits for the last read. Each item then passes the read stage,
// the x and y blend stages and the result queue, which drives m_tvalid.
// Reset empties both queues and the pipeline and sets the size registers to
// 256; the image RAM is not cleared, so sample only pixels already written.
// When m_tready stays low the 8-entry result queue fills, the back end holds,
// the 4-entry operation queue fills and s_tready drops; nothing is lost.
`default_nettype none

module bilinear_pixel_sampler #(
    parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // coord_x [15:0], coord_y [31:16], pixel_in [39:32]
    input  wire logic        s_tuser,   // cmd [0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // pixel_out [7:0]
    output logic             m_tuser,   // out_of_range [0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import bps_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int OP_W   = op_width(ADDR_W, FRAC_BITS);
    localparam int RES_W  = $bits(res_t);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
    localparam int QCNT_W = $clog2(OP_QDEPTH + 1);
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [CFG_W-1:0]  image_width_reg, image_width_next;
    logic [CFG_W-1:0]  image_height_reg, image_height_next;
    logic              cfg_wr;

    logic [OP_W-1:0]   op_in;
    logic [OP_W-1:0]   q_head;
    logic              q_empty, q_full, q_pop;
    logic [QCNT_W-1:0] q_count;

    logic              res_valid;
    res_t              res;
    res_t              out_head;
    logic [RES_W-1:0]  out_head_bits;
    logic              out_empty, out_full;
    logic [OCNT_W-1:0] out_count;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WIDTH:  image_width_next  = pwdata[CFG_W-1:0];
                REG_HEIGHT: image_height_next = pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= SIZE_RESET;
            image_height_reg <= SIZE_RESET;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(image_width_reg);
            REG_HEIGHT: prdata = 32'(image_height_reg);
            default:    prdata = '0;
        endcase
    end

    bps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .cmd          (s_tuser),
        .coord_x      (s_tdata[15:0]),
        .coord_y      (s_tdata[31:16]),
        .pixel_in     (s_tdata[39:32]),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .op           (op_in)
    );

    assign s_tready = !q_full;

    bps_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_QDEPTH)
    ) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && s_tready),
        .push_data (op_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full),
        .count     (q_count)
    );

    bps_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_count (out_count),
        .res_valid (res_valid),
        .res       (res)
    );

    bps_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_tvalid && m_tready),
        .head      (out_head_bits),
        .empty     (out_empty),
        .full      (out_full),
        .count     (out_count)
    );

    assign out_head = res_t'(out_head_bits);
    assign m_tvalid = !out_empty;
    assign m_tdata  = out_head.pixel;
    assign m_tuser  = out_head.oor;

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_full)
        else $error("result pushed into a full output queue");

    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !q_empty)
        else $error("accepted beat did not reach the operation queue");

    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> (q_count == QCNT_W'(OP_QDEPTH)))
        else $error("operation queue full flag and count disagree");

endmodule

`default_nettype wire
